// ===== design/chh_pkg.sv =====
// ----------------------------------------------------------------------------
// chh_pkg: shared types and constants of the contour convex hull block
// Holds the beat payload structs, the column and vertex words, the
// controller state encoding and the command and status bundles.
// ----------------------------------------------------------------------------
package chh_pkg;

  localparam int COORD_BITS = 12;

  localparam logic SIDE_UPPER = 1'b0;
  localparam logic SIDE_LOWER = 1'b1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_TOO_WIDE = 1'b1;

  typedef struct packed {
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic                  final_point;
  } in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] vertex_x;
    logic [COORD_BITS-1:0] vertex_y;
    logic                  lower_side;
    logic                  run_end;
    logic                  status;
  } out_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } vertex_t;

  typedef struct packed {
    logic                  seen;
    logic [COORD_BITS-1:0] top;
    logic [COORD_BITS-1:0] bottom;
  } col_word_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_ACCEPT,
    ST_HULL_START,
    ST_OVF_OUT,
    ST_COL_RD,
    ST_COL_GET,
    ST_TURN1,
    ST_TURN2,
    ST_LOAD_A,
    ST_PUSH,
    ST_NEXT_COL,
    ST_EMIT_RD,
    ST_EMIT_WAIT
  } state_t;

  typedef struct packed {
    logic accept_en;
    logic chain_init;
    logic side;
    logic cand_load;
    logic pop;
    logic load_a;
    logic push;
    logic col_next;
    logic emit_init;
    logic emit_read;
    logic emit_load;
    logic ovf_load;
    logic clear_init;
    logic clear_full;
    logic clear_step;
    logic span_reset;
  } cmd_t;

  typedef struct packed {
    logic last_done;
    logic overflow;
    logic col_seen;
    logic walk_last;
    logic sp_ge2;
    logic sp_ge3;
    logic turn_pop;
    logic emit_last;
    logic clr_done;
    logic out_free;
    logic lower;
  } sts_t;

endpackage

// ===== design/contour_convex_hull.sv =====
// ----------------------------------------------------------------------------
// contour_convex_hull: convex hull of a closed contour, column by column
// Collects per-column y extremes of contour points, then emits the upper
// and lower hull chains as vertex beats.
// ----------------------------------------------------------------------------
// Usage. Contour points arrive as beats on the point channel (valid/ready);
// point.final_point marks the last one. Hull vertices leave as beats on the
// vertex channel, upper chain left to right, then lower chain right to left,
// with run_end on the last beat of the contour. A contour wider than
// MAX_WIDTH columns gives a single beat with status set instead.
// Throughput: while a contour is collected, one point beat per cycle; each
// point is a read-modify-write of its column word in a three-stage pipeline.
// After the final point the hull pass runs: each column of the span is read,
// checked, pushed and advanced past, with turn tests before a push and a
// stack reload after a pop, then the vertices are emitted, then a clearing
// sweep covers each column of the span (the whole store after an
// overflow). Point beats are refused during the hull pass and the sweep.
// Reset: the block first runs a clearing sweep of all MAX_WIDTH columns with
// point_ready low. A stalled vertex beat holds in the output register; the
// hull pass waits for it, and collection of the next contour goes on.
// ----------------------------------------------------------------------------
module contour_convex_hull #(
  parameter int MAX_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          point_valid,
  output logic          point_ready,
  input  chh_pkg::in_t  point,
  output logic          vertex_valid,
  input  logic          vertex_ready,
  output chh_pkg::out_t vertex
);

  // Commands from the sequencer and status back from the datapath.
  chh_pkg::cmd_t cmd;
  chh_pkg::sts_t sts;

  chh_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // The datapath owns both memories (column extremes and vertex stack),
  // the turn multipliers and the output register.
  chh_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .point_valid  (point_valid),
    .point_ready  (point_ready),
    .point        (point),
    .vertex_valid (vertex_valid),
    .vertex_ready (vertex_ready),
    .vertex       (vertex)
  );

endmodule

// ===== design/chh_ram.sv =====
// ----------------------------------------------------------------------------
// chh_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; a read of the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
module chh_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/chh_ctrl.sv =====
// ----------------------------------------------------------------------------
// chh_ctrl: sequencer of the contour convex hull block
// Steps through clearing, point collection, the two chain walks with their
// turn tests, vertex emission or the too-wide beat, and the final clearing sweep.
// ----------------------------------------------------------------------------
module chh_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  chh_pkg::sts_t sts,
  output chh_pkg::cmd_t cmd
);

  chh_pkg::state_t state;
  chh_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chh_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      chh_pkg::ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clr_done) begin
          cmd.span_reset = 1'b1;
          state_next     = chh_pkg::ST_ACCEPT;
        end
      end
      chh_pkg::ST_ACCEPT: begin
        cmd.accept_en = 1'b1;
        if (sts.last_done) begin
          state_next = chh_pkg::ST_HULL_START;
        end
      end
      chh_pkg::ST_HULL_START: begin
        if (sts.overflow) begin
          state_next = chh_pkg::ST_OVF_OUT;
        end else begin
          cmd.chain_init = 1'b1;
          cmd.side       = chh_pkg::SIDE_UPPER;
          state_next     = chh_pkg::ST_COL_RD;
        end
      end
      chh_pkg::ST_OVF_OUT: begin
        if (sts.out_free) begin
          cmd.ovf_load   = 1'b1;
          cmd.clear_init = 1'b1;
          cmd.clear_full = 1'b1;
          state_next     = chh_pkg::ST_CLEAR;
        end
      end
      chh_pkg::ST_COL_RD: begin
        state_next = chh_pkg::ST_COL_GET;
      end
      chh_pkg::ST_COL_GET: begin
        if (sts.col_seen) begin
          cmd.cand_load = 1'b1;
          state_next    = sts.sp_ge2 ? chh_pkg::ST_TURN1 : chh_pkg::ST_PUSH;
        end else begin
          state_next = chh_pkg::ST_NEXT_COL;
        end
      end
      chh_pkg::ST_TURN1: begin
        state_next = chh_pkg::ST_TURN2;
      end
      chh_pkg::ST_TURN2: begin
        if (sts.turn_pop) begin
          cmd.pop    = 1'b1;
          state_next = sts.sp_ge3 ? chh_pkg::ST_LOAD_A : chh_pkg::ST_PUSH;
        end else begin
          state_next = chh_pkg::ST_PUSH;
        end
      end
      chh_pkg::ST_LOAD_A: begin
        cmd.load_a = 1'b1;
        state_next = chh_pkg::ST_TURN1;
      end
      chh_pkg::ST_PUSH: begin
        cmd.push   = 1'b1;
        state_next = chh_pkg::ST_NEXT_COL;
      end
      chh_pkg::ST_NEXT_COL: begin
        if (sts.walk_last) begin
          cmd.emit_init = 1'b1;
          state_next    = chh_pkg::ST_EMIT_RD;
        end else begin
          cmd.col_next = 1'b1;
          state_next   = chh_pkg::ST_COL_RD;
        end
      end
      chh_pkg::ST_EMIT_RD: begin
        cmd.emit_read = 1'b1;
        if (sts.out_free) begin
          state_next = chh_pkg::ST_EMIT_WAIT;
        end
      end
      chh_pkg::ST_EMIT_WAIT: begin
        cmd.emit_load = 1'b1;
        if (!sts.emit_last) begin
          state_next = chh_pkg::ST_EMIT_RD;
        end else if (sts.lower == chh_pkg::SIDE_LOWER) begin
          cmd.clear_init = 1'b1;
          state_next     = chh_pkg::ST_CLEAR;
        end else begin
          cmd.chain_init = 1'b1;
          cmd.side       = chh_pkg::SIDE_LOWER;
          state_next     = chh_pkg::ST_COL_RD;
        end
      end
      default: begin
        state_next = chh_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== design/chh_dp.sv =====
// ----------------------------------------------------------------------------
// chh_dp: datapath of the contour convex hull block
// Column min/max pipeline, span tracking, chain walk with the turn test,
// the vertex stack, the output register and the clearing sweep.
// ----------------------------------------------------------------------------
module chh_dp #(
  parameter int MAX_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  chh_pkg::cmd_t cmd,
  output chh_pkg::sts_t sts,
  input  logic          point_valid,
  output logic          point_ready,
  input  chh_pkg::in_t  point,
  output logic          vertex_valid,
  input  logic          vertex_ready,
  output chh_pkg::out_t vertex
);

  localparam int CB         = chh_pkg::COORD_BITS;
  localparam int IDX_BITS   = $clog2(MAX_WIDTH);
  localparam int SP_BITS    = $clog2(MAX_WIDTH + 1);
  localparam int QSHIFT     = 2 * CB + 1;
  localparam int QPROD_BITS = QSHIFT + CB;
  localparam longint RECIP_L =
    ((longint'(1) << QSHIFT) + longint'(MAX_WIDTH) - 1) / longint'(MAX_WIDTH);
  localparam logic [QSHIFT-1:0]   RECIP    = QSHIFT'(RECIP_L);
  localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(MAX_WIDTH - 1);
  localparam logic [SP_BITS-1:0]  SP_DEPTH = SP_BITS'(MAX_WIDTH);

  // Point pipeline.
  logic                  accept;
  logic [QPROD_BITS-1:0] qprod;
  logic                  p1_valid;
  logic                  p1_last;
  logic [CB-1:0]         p1_x;
  logic [CB-1:0]         p1_y;
  logic [CB-1:0]         p1_q;
  logic [QSHIFT-1:0]     qm;
  logic [CB-1:0]         rem;
  logic [IDX_BITS-1:0]   idx1;
  logic                  p2_valid;
  logic                  p2_last;
  logic [CB-1:0]         p2_x;
  logic [CB-1:0]         p2_y;
  logic [IDX_BITS-1:0]   p2_idx;

  // Column memory and its write forwarding.
  chh_pkg::col_word_t    col_rdata;
  chh_pkg::col_word_t    col_wdata;
  chh_pkg::col_word_t    col_old;
  chh_pkg::col_word_t    col_new;
  logic                  col_we;
  logic [IDX_BITS-1:0]   col_waddr;
  logic [IDX_BITS-1:0]   col_raddr;
  logic                  fwd_valid;
  logic [IDX_BITS-1:0]   fwd_idx;
  chh_pkg::col_word_t    fwd_word;

  // Span.
  logic [CB-1:0]         left_x;
  logic [CB-1:0]         right_x;
  logic [CB-1:0]         left_x_next;
  logic [CB-1:0]         right_x_next;
  logic [IDX_BITS-1:0]   left_idx;
  logic [IDX_BITS-1:0]   right_idx;
  logic                  ovf;
  logic                  span_wide;
  logic [CB-1:0]         span_m1;

  // Chain walk and stack.
  logic                  lower;
  logic [IDX_BITS-1:0]   walk_k;
  logic [IDX_BITS-1:0]   col_idx;
  logic [CB-1:0]         col_x;
  chh_pkg::vertex_t      cand;
  chh_pkg::vertex_t      stk_top;
  chh_pkg::vertex_t      stk_next;
  chh_pkg::vertex_t      stk_rdata;
  logic [SP_BITS-1:0]    sp;
  logic [SP_BITS-1:0]    sp_m3;
  logic [IDX_BITS-1:0]   stk_raddr;
  logic signed [CB:0]    dx_in;
  logic signed [CB:0]    dy_in;
  logic signed [CB:0]    dx_out;
  logic signed [CB:0]    dy_out;
  logic signed [2*CB+1:0] prod_fwd;
  logic signed [2*CB+1:0] prod_back;
  logic [SP_BITS-1:0]    emit_i;

  // Clearing sweep.
  logic [IDX_BITS-1:0]   clr_idx;
  logic [IDX_BITS-1:0]   clr_k;
  logic [IDX_BITS-1:0]   clr_last;

  assign accept      = point_valid && point_ready;
  assign point_ready = cmd.accept_en && !(p1_valid && p1_last) && !(p2_valid && p2_last);

  // Column index is x mod MAX_WIDTH: quotient by reciprocal, then remainder.
  assign qprod = QPROD_BITS'(point.point_x) * QPROD_BITS'(RECIP);
  assign qm    = QSHIFT'(p1_q) * QSHIFT'(MAX_WIDTH);
  assign rem   = p1_x - qm[CB-1:0];
  assign idx1  = rem[IDX_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      p1_valid <= accept;
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_x    <= point.point_x;
      p1_y    <= point.point_y;
      p1_last <= point.final_point;
      p1_q    <= qprod[QSHIFT +: CB];
    end
    p2_x    <= p1_x;
    p2_y    <= p1_y;
    p2_last <= p1_last;
    p2_idx  <= idx1;
  end

  // Read-modify-write of the column word; the latest write is forwarded
  // because the memory returns old data for a same-cycle write.
  always_comb begin
    col_old = (fwd_valid && fwd_idx == p2_idx) ? fwd_word : col_rdata;
    col_new.seen = 1'b1;
    if (!col_old.seen) begin
      col_new.top    = p2_y;
      col_new.bottom = p2_y;
    end else begin
      col_new.top    = (p2_y > col_old.top) ? p2_y : col_old.top;
      col_new.bottom = (p2_y < col_old.bottom) ? p2_y : col_old.bottom;
    end
  end

  assign col_we    = p2_valid || cmd.clear_step;
  assign col_waddr = cmd.clear_step ? clr_idx : p2_idx;
  assign col_wdata = cmd.clear_step ? chh_pkg::col_word_t'('0) : col_new;
  assign col_raddr = cmd.accept_en ? idx1 : col_idx;

  chh_ram #(
    .WIDTH ($bits(chh_pkg::col_word_t)),
    .DEPTH (MAX_WIDTH)
  ) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (col_waddr),
    .wdata (col_wdata),
    .raddr (col_raddr),
    .rdata (col_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (col_we) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (col_we) begin
      fwd_idx  <= col_waddr;
      fwd_word <= col_wdata;
    end
  end

  // Span of touched columns and the too-wide flag.
  assign left_x_next  = (p2_x <= left_x) ? p2_x : left_x;
  assign right_x_next = (p2_x >= right_x) ? p2_x : right_x;
  assign span_wide    = (right_x_next >= left_x_next) &&
                        ((CB+1)'(right_x_next) - (CB+1)'(left_x_next) >= (CB+1)'(MAX_WIDTH));
  assign span_m1      = right_x - left_x;

  always_ff @(posedge clk) begin
    if (rst || cmd.span_reset) begin
      left_x  <= '1;
      right_x <= '0;
      ovf     <= 1'b0;
    end else if (p2_valid) begin
      left_x  <= left_x_next;
      right_x <= right_x_next;
      ovf     <= ovf | span_wide;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_valid && p2_x <= left_x) begin
      left_idx <= p2_idx;
    end
    if (p2_valid && p2_x >= right_x) begin
      right_idx <= p2_idx;
    end
  end

  // Chain walk over the columns of the span.
  always_ff @(posedge clk) begin
    if (rst) begin
      lower  <= chh_pkg::SIDE_UPPER;
      walk_k <= '0;
    end else if (cmd.chain_init) begin
      lower  <= cmd.side;
      walk_k <= '0;
    end else if (cmd.col_next) begin
      walk_k <= walk_k + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.chain_init) begin
      col_idx <= (cmd.side == chh_pkg::SIDE_LOWER) ? right_idx : left_idx;
      col_x   <= (cmd.side == chh_pkg::SIDE_LOWER) ? right_x : left_x;
    end else if (cmd.col_next) begin
      if (lower == chh_pkg::SIDE_LOWER) begin
        col_idx <= (col_idx == '0) ? IDX_LAST : col_idx - 1'b1;
        col_x   <= col_x - 1'b1;
      end else begin
        col_idx <= (col_idx == IDX_LAST) ? '0 : col_idx + 1'b1;
        col_x   <= col_x + 1'b1;
      end
    end
    if (cmd.cand_load) begin
      cand.x <= col_x;
      cand.y <= (lower == chh_pkg::SIDE_LOWER) ? col_rdata.bottom : col_rdata.top;
    end
  end

  // Turn of the top two stack entries against the candidate.
  assign dx_in  = $signed({1'b0, stk_top.x}) - $signed({1'b0, stk_next.x});
  assign dy_in  = $signed({1'b0, stk_top.y}) - $signed({1'b0, stk_next.y});
  assign dx_out = $signed({1'b0, cand.x}) - $signed({1'b0, stk_top.x});
  assign dy_out = $signed({1'b0, cand.y}) - $signed({1'b0, stk_top.y});

  always_ff @(posedge clk) begin
    prod_fwd  <= dx_in * dy_out;
    prod_back <= dy_in * dx_out;
  end

  // Stack: the two top entries live in registers, every entry in memory.
  always_ff @(posedge clk) begin
    if (rst || cmd.chain_init) begin
      sp <= '0;
    end else if (cmd.push) begin
      sp <= sp + 1'b1;
    end else if (cmd.pop) begin
      sp <= sp - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stk_next <= stk_top;
      stk_top  <= cand;
    end else if (cmd.pop) begin
      stk_top <= stk_next;
    end else if (cmd.load_a) begin
      stk_next <= stk_rdata;
    end
  end

  assign sp_m3     = sp - SP_BITS'(3);
  assign stk_raddr = cmd.emit_read ? emit_i[IDX_BITS-1:0] : sp_m3[IDX_BITS-1:0];

  chh_ram #(
    .WIDTH ($bits(chh_pkg::vertex_t)),
    .DEPTH (MAX_WIDTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (sp[IDX_BITS-1:0]),
    .wdata (cand),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst || cmd.emit_init) begin
      emit_i <= '0;
    end else if (cmd.emit_load) begin
      emit_i <= emit_i + 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_valid <= 1'b0;
    end else if (cmd.emit_load || cmd.ovf_load) begin
      vertex_valid <= 1'b1;
    end else if (vertex_ready) begin
      vertex_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      vertex.vertex_x   <= stk_rdata.x;
      vertex.vertex_y   <= stk_rdata.y;
      vertex.lower_side <= lower;
      vertex.run_end    <= (lower == chh_pkg::SIDE_LOWER) && sts.emit_last;
      vertex.status     <= chh_pkg::STATUS_OK;
    end else if (cmd.ovf_load) begin
      vertex.vertex_x   <= '0;
      vertex.vertex_y   <= '0;
      vertex.lower_side <= chh_pkg::SIDE_UPPER;
      vertex.run_end    <= 1'b1;
      vertex.status     <= chh_pkg::STATUS_TOO_WIDE;
    end
  end

  // Clearing sweep of the seen flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx  <= '0;
      clr_k    <= '0;
      clr_last <= IDX_LAST;
    end else if (cmd.clear_init) begin
      clr_idx  <= cmd.clear_full ? '0 : left_idx;
      clr_k    <= '0;
      clr_last <= cmd.clear_full ? IDX_LAST : span_m1[IDX_BITS-1:0];
    end else if (cmd.clear_step) begin
      clr_idx <= (clr_idx == IDX_LAST) ? '0 : clr_idx + 1'b1;
      clr_k   <= clr_k + 1'b1;
    end
  end

  always_comb begin
    sts.last_done = p2_valid && p2_last;
    sts.overflow  = ovf;
    sts.col_seen  = col_rdata.seen;
    sts.walk_last = (CB'(walk_k) == span_m1);
    sts.sp_ge2    = (sp >= SP_BITS'(2));
    sts.sp_ge3    = (sp >= SP_BITS'(3));
    sts.turn_pop  = (prod_fwd >= prod_back);
    sts.emit_last = (emit_i == sp - 1'b1);
    sts.clr_done  = (clr_k == clr_last);
    sts.out_free  = !vertex_valid || vertex_ready;
    sts.lower     = lower;
  end

  // A point write and a clearing write never share the column memory port.
  a_no_write_clash: assert property (@(posedge clk) disable iff (rst)
    p2_valid |-> !cmd.clear_step)
    else $error("column write clash between point update and clearing sweep");

  // The stack never grows past its depth.
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (sp < SP_DEPTH))
    else $error("vertex stack overflow");

  // A stalled result is never overwritten.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (vertex_valid && !vertex_ready) |-> !(cmd.emit_load || cmd.ovf_load))
    else $error("output register loaded while a result is stalled");

  // Once the final point is folded in, no further point is taken.
  a_final_stops_input: assert property (@(posedge clk) disable iff (rst)
    (p2_valid && p2_last) |=> !point_ready)
    else $error("point accepted after the final point of a contour");

endmodule

// ===== bench/tb_contour_convex_hull.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_contour_convex_hull: self-checking bench for the contour convex hull
// Feeds contours as point beats, predicts the hull vertex beats of every
// contour with a behavioral column store and monotone chain walk, and
// compares each vertex beat against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_contour_convex_hull;

  localparam int MAX_WIDTH  = 32;
  localparam int COORD_BITS = chh_pkg::COORD_BITS;
  localparam int COORD_MAX  = (1 << COORD_BITS) - 1;

  // Shapes of random contours. Scattered points give deep dents on both
  // chains, a thin band gives many near-zero turns, a line gives exact zero
  // turns, and a walk mimics what a contour tracer really delivers.
  typedef enum int {
    SHAPE_SCATTER,
    SHAPE_BAND,
    SHAPE_LINE,
    SHAPE_WALK
  } shape_t;

  logic clk;
  logic rst;

  // Every block input gets a known value before the first clock edge.
  logic          point_valid  = 1'b0;
  logic          vertex_ready = 1'b0;
  chh_pkg::in_t  point        = '0;
  logic          point_ready;
  logic          vertex_valid;
  chh_pkg::out_t vertex;

  contour_convex_hull #(
    .MAX_WIDTH(MAX_WIDTH)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .point_ready (point_ready),
    .point       (point),
    .vertex_valid(vertex_valid),
    .vertex_ready(vertex_ready),
    .vertex      (vertex)
  );

  // --------------------------------------------------------------------------
  // Column store of the predictor. It mirrors what the block keeps while a
  // contour is collected: the y extremes per column (indexed by x modulo the
  // store depth), the span of touched columns and a sticky too-wide flag.
  // --------------------------------------------------------------------------
  logic [COORD_BITS-1:0] col_top    [MAX_WIDTH];
  logic [COORD_BITS-1:0] col_bottom [MAX_WIDTH];
  bit                    col_seen   [MAX_WIDTH];
  logic [COORD_BITS-1:0] span_left     = '1;
  logic [COORD_BITS-1:0] span_right    = '0;
  bit                    span_too_wide = 1'b0;

  chh_pkg::in_t  contour_points [$];   // point beats still to be sent
  chh_pkg::out_t hull_expected  [$];   // vertex beats predicted and not yet seen
  chh_pkg::out_t hull_run       [$];   // scratch: vertex beats of the contour at hand
  chh_pkg::out_t hull_want;
  int            error_count = 0;

  // Handshake flags, written at the rising edge and read by the drivers at
  // the following falling edge.
  bit point_taken  = 1'b0;
  bit vertex_taken = 1'b0;

  // Idle state of both sides: a "calm" stretch sends or takes back to back.
  bit send_calm = 1'b0;
  bit take_calm = 1'b1;
  int send_wait = 0;
  int take_wait = 0;

  // --------------------------------------------------------------------------
  // Hull prediction
  // --------------------------------------------------------------------------

  // Walks the span once for one chain: left to right over the column maxima
  // for the upper chain, right to left over the column minima for the lower
  // chain. Empty columns are skipped. A vertex on the stack is popped while
  // the turn into the new point is zero or positive, so collinear vertices
  // go too; the chain ends never leave because a pop needs two stack entries.
  task automatic hull_chain(input logic side);
    chh_pkg::vertex_t      stk [MAX_WIDTH];
    int                    depth;
    int                    span;
    int                    k;
    int                    slot;
    bit                    settled;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    longint                ax, ay, bx, by, turn;
    chh_pkg::out_t         beat;
    depth = 0;
    span  = int'(span_right) - int'(span_left) + 1;
    for (k = 0; k < span && k < MAX_WIDTH; k++) begin
      cx   = (side == chh_pkg::SIDE_LOWER) ? span_right - k[COORD_BITS-1:0]
                                           : span_left + k[COORD_BITS-1:0];
      slot = cx % MAX_WIDTH;
      if (col_seen[slot]) begin
        cy      = (side == chh_pkg::SIDE_LOWER) ? col_bottom[slot] : col_top[slot];
        settled = 1'b0;
        while (depth >= 2 && !settled) begin
          ax   = longint'(stk[depth-2].x);
          ay   = longint'(stk[depth-2].y);
          bx   = longint'(stk[depth-1].x);
          by   = longint'(stk[depth-1].y);
          turn = (bx - ax) * (longint'(cy) - by) - (by - ay) * (longint'(cx) - bx);
          if (turn >= 0) begin
            depth--;
          end else begin
            settled = 1'b1;
          end
        end
        stk[depth].x = cx;
        stk[depth].y = cy;
        depth++;
      end
    end
    for (k = 0; k < depth; k++) begin
      beat            = '0;
      beat.vertex_x   = stk[k].x;
      beat.vertex_y   = stk[k].y;
      beat.lower_side = side;
      beat.status     = chh_pkg::STATUS_OK;
      hull_run.push_back(beat);
    end
  endtask

  // Folds one accepted point into the column store. The final point of a
  // contour counts as a point too; it then turns the store into the vertex
  // beats of the contour (or one too-wide beat) and empties the store.
  task automatic absorb_point(input chh_pkg::in_t pt);
    int            slot;
    int            k;
    chh_pkg::out_t beat;
    slot = pt.point_x % MAX_WIDTH;
    if (!col_seen[slot]) begin
      col_seen[slot]   = 1'b1;
      col_top[slot]    = pt.point_y;
      col_bottom[slot] = pt.point_y;
    end else begin
      if (pt.point_y > col_top[slot]) col_top[slot] = pt.point_y;
      if (pt.point_y < col_bottom[slot]) col_bottom[slot] = pt.point_y;
    end
    if (pt.point_x < span_left) span_left = pt.point_x;
    if (pt.point_x > span_right) span_right = pt.point_x;
    if (span_right >= span_left && int'(span_right) - int'(span_left) + 1 > MAX_WIDTH)
      span_too_wide = 1'b1;

    if (pt.final_point) begin
      hull_run.delete();
      if (span_too_wide) begin
        beat        = '0;
        beat.status = chh_pkg::STATUS_TOO_WIDE;
        hull_run.push_back(beat);
      end else begin
        hull_chain(chh_pkg::SIDE_UPPER);
        hull_chain(chh_pkg::SIDE_LOWER);
      end
      // Only the very last beat of the contour carries run_end.
      for (k = 0; k < hull_run.size(); k++) begin
        beat = hull_run[k];
        if (k == hull_run.size() - 1) beat.run_end = 1'b1;
        hull_expected.push_back(beat);
      end
      for (k = 0; k < MAX_WIDTH; k++) col_seen[k] = 1'b0;
      span_left     = '1;
      span_right    = '0;
      span_too_wide = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus construction
  // --------------------------------------------------------------------------

  task automatic add_point(input int px, input int py, input bit last);
    chh_pkg::in_t pt;
    pt.point_x     = px[COORD_BITS-1:0];
    pt.point_y     = py[COORD_BITS-1:0];
    pt.final_point = last;
    contour_points.push_back(pt);
  endtask

  function automatic int clamp_coord(input int v);
    return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

  // One random contour. Most fit in the column store; about one in ten is
  // given a window wider than the store, which may or may not end up too
  // wide depending on where its points land. Long contours are rarer.
  task automatic random_contour();
    int     npts, w, x0, y0, slope, px, py, i;
    shape_t shape;
    npts  = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    w     = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_WIDTH + 1, MAX_WIDTH + 16)
                                        : $urandom_range(1, MAX_WIDTH);
    x0    = $urandom_range(0, COORD_MAX + 1 - w);
    y0    = $urandom_range(0, COORD_MAX);
    slope = $urandom_range(0, 6) - 3;
    shape = shape_t'($urandom_range(0, 3));
    px    = x0 + $urandom_range(0, w - 1);
    py    = y0;
    for (i = 0; i < npts; i++) begin
      case (shape)
        SHAPE_SCATTER: begin
          px = x0 + $urandom_range(0, w - 1);
          py = $urandom_range(0, COORD_MAX);
        end
        SHAPE_BAND: begin
          px = x0 + $urandom_range(0, w - 1);
          py = clamp_coord(y0 + $urandom_range(0, 15));
        end
        SHAPE_LINE: begin
          px = x0 + $urandom_range(0, w - 1);
          py = clamp_coord(y0 + slope * (px - x0));
        end
        default: begin
          // One step to one of the eight neighbors or none, kept in the window.
          px = px + $urandom_range(0, 2) - 1;
          if (px < x0) px = x0;
          if (px > x0 + w - 1) px = x0 + w - 1;
          py = clamp_coord(py + $urandom_range(0, 2) - 1);
        end
      endcase
      add_point(px, py, i == npts - 1);
    end
  endtask

  // Pause before the next beat on one side. A calm stretch has no pauses;
  // otherwise short pauses dominate with an occasional long one.
  task automatic draw_pause(inout bit calm, output int len);
    if ($urandom_range(0, 31) == 0) calm = !calm;
    if (calm) begin
      len = 0;
    end else if ($urandom_range(0, 3) == 0) begin
      len = $urandom_range(0, 16);
    end else begin
      len = $urandom_range(0, 2);
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (5) @(negedge clk);
    rst = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Point driver: presents the queued beats at the falling edge, holds a
  // beat until it is taken, then waits its drawn pause before the next one.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else if (!point_valid || point_taken) begin
      if (send_wait != 0) begin
        point_valid <= 1'b0;
        send_wait = send_wait - 1;
      end else if (contour_points.size() != 0) begin
        point       <= contour_points.pop_front();
        point_valid <= 1'b1;
        draw_pause(send_calm, send_wait);
      end else begin
        point_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Vertex receiver: after each taken beat it may hold ready low for a while,
  // so that stalls land on every phase of the hull pass and the emit loop.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      vertex_ready <= 1'b0;
    end else begin
      if (vertex_taken) draw_pause(take_calm, take_wait);
      if (take_wait != 0) begin
        vertex_ready <= 1'b0;
        take_wait = take_wait - 1;
      end else begin
        vertex_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: at each rising edge, an accepted point feeds the predictor and
  // an accepted vertex beat is checked against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      point_taken  = 1'b0;
      vertex_taken = 1'b0;
    end else begin
      point_taken  = point_valid && point_ready;
      vertex_taken = vertex_valid && vertex_ready;
      if (point_taken) absorb_point(point);
      if (vertex_taken) begin
        if (hull_expected.size() == 0) begin
          error_count++;
          $display("%0t: unexpected vertex beat: x=%0d y=%0d lower=%0b end=%0b status=%0b",
                   $time, vertex.vertex_x, vertex.vertex_y, vertex.lower_side,
                   vertex.run_end, vertex.status);
        end else begin
          hull_want = hull_expected.pop_front();
          if (vertex.vertex_x   !== hull_want.vertex_x   ||
              vertex.vertex_y   !== hull_want.vertex_y   ||
              vertex.lower_side !== hull_want.lower_side ||
              vertex.run_end    !== hull_want.run_end    ||
              vertex.status     !== hull_want.status) begin
            error_count++;
            $display("%0t: vertex mismatch: expected x=%0d y=%0d lower=%0b end=%0b status=%0b",
                     $time, hull_want.vertex_x, hull_want.vertex_y, hull_want.lower_side,
                     hull_want.run_end, hull_want.status);
            $display("%0t:                  actual   x=%0d y=%0d lower=%0b end=%0b status=%0b",
                     $time, vertex.vertex_x, vertex.vertex_y, vertex.lower_side,
                     vertex.run_end, vertex.status);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    // Lone points at both corners: a single column is one vertex per chain.
    add_point(0, 0, 1'b1);
    add_point(COORD_MAX, COORD_MAX, 1'b1);
    // Two points in one column, so the chains differ in y.
    add_point(7, 10, 1'b0);
    add_point(7, 4000, 1'b1);
    // A span of exactly the store depth still gives a hull.
    add_point(100, 5, 1'b0);
    add_point(100 + MAX_WIDTH - 1, COORD_MAX, 1'b1);
    // One column more is too wide.
    add_point(200, 0, 1'b0);
    add_point(200 + MAX_WIDTH, 0, 1'b1);
    // The full x range, right end first, is too wide as well.
    add_point(COORD_MAX, 0, 1'b0);
    add_point(0, COORD_MAX, 1'b1);
    // A straight line: every inner vertex has a turn of zero and goes.
    add_point(10, 100, 1'b0);
    add_point(11, 101, 1'b0);
    add_point(12, 102, 1'b0);
    add_point(13, 103, 1'b1);
    // Empty columns, a dent on top and a span whose store index wraps.
    add_point(28, 2000, 1'b0);
    add_point(30, 3000, 1'b0);
    add_point(33, 1000, 1'b0);
    add_point(36, 3500, 1'b0);
    add_point(40, 0, 1'b0);
    add_point(34, COORD_MAX, 1'b1);
    // The last full-depth span at the right edge of the x range.
    add_point(COORD_MAX + 1 - MAX_WIDTH, 1, 1'b0);
    add_point(COORD_MAX, 2, 1'b1);

    while (contour_points.size() < 520) random_contour();

    // Drain: all beats sent, all predictions met, then a quiet stretch long
    // enough for the clearing sweep and any stray vertex beat to show up.
    @(negedge rst);
    while (contour_points.size() != 0 || point_valid) @(posedge clk);
    while (hull_expected.size() != 0) @(posedge clk);
    repeat (4 * MAX_WIDTH) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_contour_convex_hull: clean");
    end else begin
      $display("tb_contour_convex_hull: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("tb_contour_convex_hull: errors");
    $finish;
  end

endmodule
